// ===== hw/rtl/jmve_pkg.sv =====
// ----------------------------------------------------------------------------
// jmve_pkg
// Shared types, codes and the string decode step of the member value extractor.
// ----------------------------------------------------------------------------
package jmve_pkg;

   localparam int NestDepthDefault   = 16;
   localparam int KeyMaxBytesDefault = 32;
   localparam int CsrAddrWidth       = 6;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOTFOUND  = 3'd1,
      ST_MALFORMED = 3'd2,
      ST_WRONGTYPE = 3'd3,
      ST_OVERFLOW  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      REG_KEY0    = 3'd0,
      REG_KEY1    = 3'd1,
      REG_KEY2    = 3'd2,
      REG_KEY3    = 3'd3,
      REG_KEYLEN  = 3'd4,
      REG_MODE    = 3'd5,
      REG_LIMIT   = 3'd6
   } reg_index_type;

   typedef enum logic [13:0] {
      PH_OPEN       = 14'b00000000000001,
      PH_MEMBER     = 14'b00000000000010,
      PH_KEY        = 14'b00000000000100,
      PH_COLON      = 14'b00000000001000,
      PH_VSTART     = 14'b00000000010000,
      PH_SKIP_STR   = 14'b00000000100000,
      PH_NEST       = 14'b00000001000000,
      PH_NEST_STR   = 14'b00000010000000,
      PH_SCALAR     = 14'b00000100000000,
      PH_AFTER_SKIP = 14'b00001000000000,
      PH_VSTR       = 14'b00010000000000,
      PH_VNUM       = 14'b00100000000000,
      PH_AFTER_VAL  = 14'b01000000000000,
      PH_DONE       = 14'b10000000000000
   } phase_type;

   typedef enum logic [1:0] {
      SD_NONE = 2'd0,
      SD_CHAR = 2'd1,
      SD_END  = 2'd2,
      SD_FAIL = 2'd3
   } sd_kind_type;

   localparam logic [2:0] EscNormal = 3'd0;
   localparam logic [2:0] EscBslash = 3'd1;
   localparam logic [2:0] EscHex0   = 3'd2;
   localparam logic [2:0] EscHexEnd = 3'd5;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  value_byte;
      logic [2:0]  status;
      logic [63:0] number;
      logic        truncated;
   } rsp_type;

   typedef struct packed {
      sd_kind_type kind;
      logic [7:0]  ch;
      logic [2:0]  esc;
   } sd_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   // one byte of string content, opening quote already taken
   function automatic sd_type str_decode(input logic [7:0] c, input logic [2:0] esc);
      sd_type r;
      r.kind = SD_NONE;
      r.ch   = c;
      r.esc  = EscNormal;
      if (esc == EscNormal) begin
         if (c == "\"") r.kind = SD_END;
         else if (c < 8'h20) r.kind = SD_FAIL;
         else if (c == "\\") r.esc = EscBslash;
         else r.kind = SD_CHAR;
      end else if (esc == EscBslash) begin
         case (c) inside
            "\"", "\\", "/": r.kind = SD_CHAR;
            "b": begin r.kind = SD_CHAR; r.ch = 8'h08; end
            "f": begin r.kind = SD_CHAR; r.ch = 8'h0C; end
            "n": begin r.kind = SD_CHAR; r.ch = 8'h0A; end
            "r": begin r.kind = SD_CHAR; r.ch = 8'h0D; end
            "t": begin r.kind = SD_CHAR; r.ch = 8'h09; end
            "u": r.esc = EscHex0;
            default: r.kind = SD_FAIL;
         endcase
      end else begin
         if (!is_hex(c)) r.kind = SD_FAIL;
         else if (esc == EscHexEnd) begin
            r.kind = SD_CHAR;
            r.ch   = "?";
         end else r.esc = esc + 3'd1;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/json_member_value_extract.sv =====
// ----------------------------------------------------------------------------
// json_member_value_extract
// Scans a JSON object byte by byte and extracts the value of one member.
// ----------------------------------------------------------------------------
// The req channel carries one document byte per beat; a beat with
// end_of_text set closes the document and rearms the scanner. Each accepted
// byte is handled in the cycle it is taken: phase, escape, nesting stack and
// decimal accumulator all update in one pass, so a byte can be accepted on
// every clock. A byte produces at most one rsp beat: a decoded string value
// byte (result_kind 0) or the single verdict of the document (result_kind 1).
// Results appear on the rsp port the cycle after the byte is accepted and sit
// in one output register; req_stall rises only while that register is full
// and the receiver stalls it; with no rsp_stall the rate is one byte per cycle.
// Value bytes are provisional; a later failure verdict overrides them.
// The key, key length, mode and output limit live in csr registers; the user
// writes them over the APB-style port only while no document is in flight;
// the block does not enforce it. Reset returns the scanner to waiting for
// the opening brace, empties the output register and resets the csr registers.
// ----------------------------------------------------------------------------
module json_member_value_extract #(
   parameter int NEST_DEPTH    = jmve_pkg::NestDepthDefault,
   parameter int KEY_MAX_BYTES = jmve_pkg::KeyMaxBytesDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  jmve_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output jmve_pkg::rsp_type               rsp_payload,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [jmve_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [63:0]                     csr_pwdata,
   output logic [63:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int DW = $clog2(NEST_DEPTH + 1);
   localparam int IW = $clog2(NEST_DEPTH);

   // csr registers
   logic [63:0] key_ff [4];
   logic [5:0]  key_len_ff;
   logic        mode_ff;
   logic [8:0]  limit_ff;

   jmve_pkg::reg_index_type csr_idx;
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = jmve_pkg::reg_index_type'(csr_paddr[5:3]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         key_len_ff <= 6'd1;
         mode_ff    <= 1'b0;
         limit_ff   <= 9'd64;
      end else if (csr_wr) begin
         unique case (csr_idx)
            jmve_pkg::REG_KEY0:   key_ff[0]  <= csr_pwdata;
            jmve_pkg::REG_KEY1:   key_ff[1]  <= csr_pwdata;
            jmve_pkg::REG_KEY2:   key_ff[2]  <= csr_pwdata;
            jmve_pkg::REG_KEY3:   key_ff[3]  <= csr_pwdata;
            jmve_pkg::REG_KEYLEN: key_len_ff <= csr_pwdata[5:0];
            jmve_pkg::REG_MODE:   mode_ff    <= csr_pwdata[0];
            jmve_pkg::REG_LIMIT:  limit_ff   <= csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         jmve_pkg::REG_KEY0:   csr_prdata = key_ff[0];
         jmve_pkg::REG_KEY1:   csr_prdata = key_ff[1];
         jmve_pkg::REG_KEY2:   csr_prdata = key_ff[2];
         jmve_pkg::REG_KEY3:   csr_prdata = key_ff[3];
         jmve_pkg::REG_KEYLEN: csr_prdata = {58'd0, key_len_ff};
         jmve_pkg::REG_MODE:   csr_prdata = {63'd0, mode_ff};
         jmve_pkg::REG_LIMIT:  csr_prdata = {55'd0, limit_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // scanner state
   jmve_pkg::phase_type phase_ff, phase_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic          stack_ff [NEST_DEPTH];
   logic [2:0]    esc_ff, esc_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic          mis_ff, mis_in;
   logic [63:0]   acc_ff, acc_in;
   logic [7:0]    emit_cnt_ff, emit_cnt_in;
   logic          trunc_ff, trunc_in;
   logic          done_ff, done_in;

   jmve_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic accept;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   logic [7:0]      c;
   logic            ws, dig, open_br, is_obj;
   jmve_pkg::sd_type sd;
   logic [255:0]    key_bits;
   logic [7:0]      key_b;
   logic [DW-1:0]   depth_m1;
   logic            top;
   logic [8:0]      lim;
   logic [67:0]     acc_x10;
   logic            push, push0;
   logic            emit, do_verdict;
   jmve_pkg::status_type vstat;

   assign c        = req_payload.text_byte;
   assign ws       = jmve_pkg::is_ws(c);
   assign dig      = jmve_pkg::is_digit(c);
   assign open_br  = (c == "{") || (c == "[");
   assign is_obj   = (c == "{") || (c == "}");
   assign sd       = jmve_pkg::str_decode(c, esc_ff);
   assign key_bits = {key_ff[3], key_ff[2], key_ff[1], key_ff[0]};
   assign key_b    = key_bits[cnt_ff[4:0]*8 +: 8];
   assign depth_m1 = depth_ff - DW'(1);
   assign top      = stack_ff[depth_m1[IW-1:0]];
   assign lim      = (limit_ff == 9'd0) ? 9'd1 : (limit_ff > 9'd256 ? 9'd256 : limit_ff);
   // acc*10 + digit, overflow shows in the top bits
   assign acc_x10  = {1'b0, acc_ff, 3'b0} + {3'b0, acc_ff, 1'b0} + {64'd0, c[3:0] - 4'd0};

   always_comb begin
      phase_in    = phase_ff;
      depth_in    = depth_ff;
      esc_in      = esc_ff;
      cnt_in      = cnt_ff;
      mis_in      = mis_ff;
      acc_in      = acc_ff;
      emit_cnt_in = emit_cnt_ff;
      trunc_in    = trunc_ff;
      done_in     = done_ff;
      push        = 1'b0;
      push0       = 1'b0;
      emit        = 1'b0;
      do_verdict  = 1'b0;
      vstat       = jmve_pkg::ST_OK;
      rsp_in      = '0;

      if (req_payload.end_of_text) begin
         if (!done_ff) begin
            do_verdict = 1'b1;
            vstat      = jmve_pkg::ST_MALFORMED;
         end
      end else begin
         unique case (phase_ff) inside
            jmve_pkg::PH_OPEN: begin
               if (!ws) begin
                  if (c == "{") phase_in = jmve_pkg::PH_MEMBER;
                  else begin do_verdict = 1'b1; vstat = jmve_pkg::ST_MALFORMED; end
               end
            end
            jmve_pkg::PH_MEMBER: begin
               if (!ws) begin
                  if (c == "}") begin
                     do_verdict = 1'b1; vstat = jmve_pkg::ST_NOTFOUND;
                  end else if (c != "\"") begin
                     do_verdict = 1'b1; vstat = jmve_pkg::ST_MALFORMED;
                  end else begin
                     cnt_in   = '0;
                     mis_in   = 1'b0;
                     esc_in   = jmve_pkg::EscNormal;
                     phase_in = jmve_pkg::PH_KEY;
                  end
               end
            end
            jmve_pkg::PH_KEY: begin
               esc_in = sd.esc;
               case (sd.kind)
                  jmve_pkg::SD_FAIL: begin
                     do_verdict = 1'b1; vstat = jmve_pkg::ST_MALFORMED;
                  end
                  jmve_pkg::SD_CHAR: begin
                     if (cnt_ff >= {1'b0, key_len_ff} || cnt_ff >= 7'(KEY_MAX_BYTES)
                         || key_b != sd.ch)
                        mis_in = 1'b1;
                     if (cnt_ff < 7'd127) cnt_in = cnt_ff + 7'd1;
                  end
                  jmve_pkg::SD_END: begin
                     if (cnt_ff != {1'b0, key_len_ff} || key_len_ff == 6'd0
                         || {1'b0, key_len_ff} > 7'(KEY_MAX_BYTES))
                        mis_in = 1'b1;
                     phase_in = jmve_pkg::PH_COLON;
                  end
                  default: ;
               endcase
            end
            jmve_pkg::PH_COLON: begin
               if (!ws) begin
                  if (c == ":") phase_in = jmve_pkg::PH_VSTART;
                  else begin do_verdict = 1'b1; vstat = jmve_pkg::ST_MALFORMED; end
               end
            end
            jmve_pkg::PH_VSTART: begin
               if (!ws) begin
                  if (!mis_ff) begin
                     if (!mode_ff) begin
                        if (c != "\"") begin
                           do_verdict = 1'b1; vstat = jmve_pkg::ST_WRONGTYPE;
                        end else begin
                           esc_in   = jmve_pkg::EscNormal;
                           phase_in = jmve_pkg::PH_VSTR;
                        end
                     end else begin
                        if (!dig) begin
                           do_verdict = 1'b1; vstat = jmve_pkg::ST_WRONGTYPE;
                        end else begin
                           acc_in   = {60'd0, c[3:0]};
                           phase_in = jmve_pkg::PH_VNUM;
                        end
                     end
                  end else if (c == "\"") begin
                     esc_in   = jmve_pkg::EscNormal;
                     phase_in = jmve_pkg::PH_SKIP_STR;
                  end else if (open_br) begin
                     push0    = 1'b1;
                     depth_in = DW'(1);
                     phase_in = jmve_pkg::PH_NEST;
                  end else if (c == "," || c == "}") begin
                     do_verdict = 1'b1; vstat = jmve_pkg::ST_MALFORMED;
                  end else phase_in = jmve_pkg::PH_SCALAR;
               end
            end
            jmve_pkg::PH_SKIP_STR, jmve_pkg::PH_NEST_STR: begin
               esc_in = sd.esc;
               if (sd.kind == jmve_pkg::SD_FAIL) begin
                  do_verdict = 1'b1; vstat = jmve_pkg::ST_MALFORMED;
               end else if (sd.kind == jmve_pkg::SD_END) begin
                  phase_in = (phase_ff == jmve_pkg::PH_SKIP_STR) ?
                             jmve_pkg::PH_AFTER_SKIP : jmve_pkg::PH_NEST;
               end
            end
            jmve_pkg::PH_NEST: begin
               if (c == "\"") begin
                  esc_in   = jmve_pkg::EscNormal;
                  phase_in = jmve_pkg::PH_NEST_STR;
               end else if (open_br) begin
                  if (depth_ff >= DW'(NEST_DEPTH)) begin
                     do_verdict = 1'b1; vstat = jmve_pkg::ST_MALFORMED;
                  end else begin
                     push     = 1'b1;
                     depth_in = depth_ff + DW'(1);
                  end
               end else if (c == "}" || c == "]") begin
                  if (depth_ff == '0 || top != is_obj) begin
                     do_verdict = 1'b1; vstat = jmve_pkg::ST_MALFORMED;
                  end else begin
                     depth_in = depth_m1;
                     if (depth_m1 == '0) phase_in = jmve_pkg::PH_AFTER_SKIP;
                  end
               end
            end
            jmve_pkg::PH_SCALAR: begin
               if (c == ",") phase_in = jmve_pkg::PH_MEMBER;
               else if (c == "}") begin
                  do_verdict = 1'b1; vstat = jmve_pkg::ST_NOTFOUND;
               end
            end
            jmve_pkg::PH_AFTER_SKIP: begin
               if (!ws) begin
                  if (c == ",") phase_in = jmve_pkg::PH_MEMBER;
                  else begin
                     do_verdict = 1'b1;
                     vstat = (c == "}") ? jmve_pkg::ST_NOTFOUND : jmve_pkg::ST_MALFORMED;
                  end
               end
            end
            jmve_pkg::PH_VSTR: begin
               esc_in = sd.esc;
               if (sd.kind == jmve_pkg::SD_FAIL) begin
                  do_verdict = 1'b1; vstat = jmve_pkg::ST_MALFORMED;
               end else if (sd.kind == jmve_pkg::SD_END) begin
                  phase_in = jmve_pkg::PH_AFTER_VAL;
               end else if (sd.kind == jmve_pkg::SD_CHAR) begin
                  if ({1'b0, emit_cnt_ff} + 9'd1 < lim) begin
                     emit_cnt_in        = emit_cnt_ff + 8'd1;
                     emit               = 1'b1;
                     rsp_in.value_byte  = sd.ch;
                  end else trunc_in = 1'b1;
               end
            end
            jmve_pkg::PH_VNUM: begin
               if (dig) begin
                  if (acc_x10[67:64] != 4'd0) begin
                     do_verdict = 1'b1; vstat = jmve_pkg::ST_OVERFLOW;
                  end else acc_in = acc_x10[63:0];
               end else if (ws) phase_in = jmve_pkg::PH_AFTER_VAL;
               else begin
                  do_verdict = 1'b1;
                  vstat = (c == "," || c == "}") ? jmve_pkg::ST_OK : jmve_pkg::ST_MALFORMED;
               end
            end
            jmve_pkg::PH_AFTER_VAL: begin
               if (!ws) begin
                  do_verdict = 1'b1;
                  vstat = (c == "," || c == "}") ? jmve_pkg::ST_OK : jmve_pkg::ST_MALFORMED;
               end
            end
            jmve_pkg::PH_DONE: ;
            default: ;
         endcase
      end

      if (do_verdict) begin
         emit               = 1'b1;
         rsp_in.result_kind = 1'b1;
         rsp_in.status      = vstat;
         rsp_in.number      = (vstat == jmve_pkg::ST_OK && mode_ff) ? acc_ff : 64'd0;
         rsp_in.truncated   = trunc_ff;
         done_in            = 1'b1;
         phase_in           = jmve_pkg::PH_DONE;
      end

      // end of text rearms the document
      if (req_payload.end_of_text) begin
         phase_in    = jmve_pkg::PH_OPEN;
         depth_in    = '0;
         esc_in      = jmve_pkg::EscNormal;
         cnt_in      = '0;
         mis_in      = 1'b0;
         acc_in      = '0;
         emit_cnt_in = '0;
         trunc_in    = 1'b0;
         done_in     = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept && emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= jmve_pkg::PH_OPEN;
         depth_ff     <= '0;
         esc_ff       <= jmve_pkg::EscNormal;
         cnt_ff       <= '0;
         mis_ff       <= 1'b0;
         acc_ff       <= '0;
         emit_cnt_ff  <= '0;
         trunc_ff     <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff    <= phase_in;
            depth_ff    <= depth_in;
            esc_ff      <= esc_in;
            cnt_ff      <= cnt_in;
            mis_ff      <= mis_in;
            acc_ff      <= acc_in;
            emit_cnt_ff <= emit_cnt_in;
            trunc_ff    <= trunc_in;
            done_ff     <= done_in;
         end
      end
   end

   // nesting stack, 1 marks a brace
   always_ff @(posedge clock) begin
      if (accept && !req_payload.end_of_text) begin
         if (push0) stack_ff[0] <= (c == "{");
         else if (push) stack_ff[depth_ff[IW-1:0]] <= (c == "{");
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(NEST_DEPTH))
      else $error("nesting depth beyond stack size");

   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      done_ff == (phase_ff == jmve_pkg::PH_DONE))
      else $error("verdict flag and phase disagree");

   a_eot_rearm: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.end_of_text |=> phase_ff == jmve_pkg::PH_OPEN && !done_ff)
      else $error("end of text did not rearm the scanner");

   a_verdict_once: assert property (@(posedge clock) disable iff (reset)
      accept && done_ff && !req_payload.end_of_text |=> !rsp_valid || $past(rsp_valid))
      else $error("result after the verdict");
`endif

endmodule
